// ----- rtl/bounded_substring_search_assert.svh -----
// Assertion macros shared by the bounded substring search RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
// Every module that uses these macros has ports named clk and arst_n.
`ifndef BOUNDED_SUBSTRING_SEARCH_ASSERT_SVH
`define BOUNDED_SUBSTRING_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// A check that is switched off while reset is asserted.
`define BSS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");
// A check that must also hold on every clock edge during reset.
`define BSS_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("%m: check failed");
`else
`define BSS_ASSERT(label, prop)
`define BSS_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- rtl/bss_pkg.sv -----
// Package for the bounded substring search: register codes, queue sizing,
// the queue entry types and the needle byte selection function. No dependencies.
package bss_pkg;

	// Default sizing handed to the top-level parameters.
	localparam int DEF_MAX_NEEDLE = 16;
	localparam int DEF_POS_WIDTH  = 16;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Index width of the needle byte selector (covers up to 128 bytes).
	localparam int NB_IDX_W = 7;

	// Queue between the front and the back; the depth is a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEEDLE_LEN   = 2'd0,
		REG_NEEDLE_LO    = 2'd1,
		REG_NEEDLE_HI    = 2'd2,
		REG_SEARCH_LIMIT = 2'd3
	} bss_reg_t;

	// One classified haystack byte as it sits in the queue.
	typedef struct packed {
		logic [7:0] hay_byte;
		logic       first;
		logic       term;
	} bss_item_t;

	// Head of the queue as seen by the back.
	typedef struct packed {
		logic      valid;
		bss_item_t item;
	} bss_head_t;

	// Needle byte j; bytes at index 16 and above read as zero.
	function automatic logic [7:0] needle_byte(input logic [63:0] lo, input logic [63:0] hi,
		input logic [NB_IDX_W-1:0] j);
		logic [5:0] sel;
		sel = {j[2:0], 3'b000};
		if (j < NB_IDX_W'(8)) begin
			return lo[sel +: 8];
		end else if (j < NB_IDX_W'(16)) begin
			return hi[sel +: 8];
		end
		return 8'h00;
	endfunction

endpackage

// ----- rtl/bss_in_if.sv -----
// Haystack input channel of the bounded substring search.
// Carries valid, ready and one haystack byte with its start flag; no dependencies.
interface bss_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] hay_byte;
	logic       first;

	modport source(output valid, output hay_byte, output first, input ready);
	modport sink(input valid, input hay_byte, input first, output ready);
endinterface

// ----- rtl/bss_out_if.sv -----
// Result channel of the bounded substring search.
// Carries valid, ready and the search status; its default width comes from bss_pkg.
interface bss_out_if #(
	parameter int POS_WIDTH = bss_pkg::DEF_POS_WIDTH
);
	logic                 valid;
	logic                 ready;
	logic                 finished;
	logic                 found;
	logic [POS_WIDTH-1:0] match_pos;

	modport source(output valid, output finished, output found, output match_pos, input ready);
	modport sink(input valid, input finished, input found, input match_pos, output ready);
endinterface

// ----- rtl/bss_cfg.sv -----
// Configuration registers of the bounded substring search and the values derived
// from them: effective needle length, reversed needle pattern, compare mask, limit.
// Depends on bss_pkg.
module bss_cfg #(
	parameter int MAX_NEEDLE = bss_pkg::DEF_MAX_NEEDLE,
	parameter int POS_WIDTH  = bss_pkg::DEF_POS_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [bss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bss_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [$clog2(MAX_NEEDLE+1)-1:0]     eff_len,
	output logic [MAX_NEEDLE-1:0][7:0]          pattern,
	output logic [MAX_NEEDLE-1:0]               mask,
	output logic [POS_WIDTH-1:0]                limit
);
	import bss_pkg::*;

	localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
	localparam int NL_W  = (LEN_W > 5) ? LEN_W : 5;

	logic [4:0]              needle_len_q;
	logic [63:0]             needle_lo_q;
	logic [63:0]             needle_hi_q;
	logic [15:0]             search_limit_q;

	logic [NL_W-1:0]         nl_ext;
	logic [LEN_W-1:0]        n_clamp;
	logic [LEN_W-1:0]        eff_c;
	logic [MAX_NEEDLE-1:0][7:0] pat_c;
	logic [MAX_NEEDLE-1:0]   mask_c;

	logic [LEN_W-1:0]        eff_len_q;
	logic [MAX_NEEDLE-1:0][7:0] pattern_q;
	logic [MAX_NEEDLE-1:0]   mask_q;
	logic [POS_WIDTH-1:0]    limit_q;

	// Register writes from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_len_q   <= '0;
			needle_lo_q    <= '0;
			needle_hi_q    <= '0;
			search_limit_q <= '0;
		end else if (cfg_wen) begin
			case (bss_reg_t'(cfg_index))
				REG_NEEDLE_LEN:   needle_len_q   <= cfg_data[4:0];
				REG_NEEDLE_LO:    needle_lo_q    <= cfg_data;
				REG_NEEDLE_HI:    needle_hi_q    <= cfg_data;
				REG_SEARCH_LIMIT: search_limit_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Length saturated to the window depth.
	assign nl_ext = NL_W'(needle_len_q);

	always_comb begin
		if (nl_ext > NL_W'(MAX_NEEDLE)) begin
			n_clamp = LEN_W'(MAX_NEEDLE);
		end else begin
			n_clamp = LEN_W'(nl_ext);
		end
	end

	// The needle is a zero-terminated string: cut it at its first zero byte.
	always_comb begin
		eff_c = n_clamp;
		for (int j = MAX_NEEDLE - 1; j >= 0; j--) begin
			if ((LEN_W'(j) < n_clamp) &&
				(needle_byte(needle_lo_q, needle_hi_q, NB_IDX_W'(j)) == 8'h00)) begin
				eff_c = LEN_W'(j);
			end
		end
	end

	// Window slot k holds the byte that must equal needle byte eff_len-1-k.
	always_comb begin
		logic [LEN_W-1:0] idx;
		idx = '0;
		for (int k = 0; k < MAX_NEEDLE; k++) begin
			if (LEN_W'(k) < eff_c) begin
				idx       = eff_c - LEN_W'(k) - LEN_W'(1);
				pat_c[k]  = needle_byte(needle_lo_q, needle_hi_q, NB_IDX_W'(idx));
				mask_c[k] = 1'b1;
			end else begin
				pat_c[k]  = 8'h00;
				mask_c[k] = 1'b0;
			end
		end
	end

	// Derived values are registered from the configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_len_q <= '0;
			pattern_q <= '0;
			mask_q    <= '0;
			limit_q   <= '0;
		end else begin
			eff_len_q <= eff_c;
			pattern_q <= pat_c;
			mask_q    <= mask_c;
			limit_q   <= POS_WIDTH'(search_limit_q);
		end
	end

	assign eff_len = eff_len_q;
	assign pattern = pattern_q;
	assign mask    = mask_q;
	assign limit   = limit_q;

endmodule

// ----- rtl/bss_front.sv -----
// Front of the bounded substring search: accepts haystack transactions, marks
// terminator bytes and holds them in a short queue for the back. Depends on bss_pkg.
module bss_front (
	input  logic               clk,
	input  logic               arst_n,
	bss_in_if.sink             hay,
	output bss_pkg::bss_head_t head,
	input  logic               pop
);
	import bss_pkg::*;

	`include "bounded_substring_search_assert.svh"

	localparam int CNT_W = QUEUE_PTR_W + 1;

	bss_item_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic                   push;
	bss_item_t              item_c;

	// Accept while the queue has room.
	assign hay.ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push      = hay.valid && hay.ready;

	// Classify the incoming byte.
	always_comb begin
		item_c.hay_byte = hay.hay_byte;
		item_c.first    = hay.first;
		item_c.term     = (hay.hay_byte == 8'h00);
	end

	// Queue storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_c;
		end
	end

	// Next fill count.
	assign count_d = count_q + CNT_W'(push) - CNT_W'(pop);

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			count_q <= count_d;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	`BSS_ASSERT(a_queue_bound, count_q <= CNT_W'(QUEUE_DEPTH))
	`BSS_ASSERT(a_no_underflow, pop |-> (count_q != '0))
	`BSS_ASSERT(a_count_tracks, $past(arst_n) |-> (count_q == $past(count_d)))

endmodule

// ----- rtl/bss_back.sv -----
// Back of the bounded substring search: the window shift register, byte counter
// and search status, with the result output register. Depends on bss_pkg.
module bss_back #(
	parameter int MAX_NEEDLE = bss_pkg::DEF_MAX_NEEDLE,
	parameter int POS_WIDTH  = bss_pkg::DEF_POS_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bss_pkg::bss_head_t              head,
	output logic                            pop,
	input  logic [$clog2(MAX_NEEDLE+1)-1:0] eff_len,
	input  logic [MAX_NEEDLE-1:0][7:0]      pattern,
	input  logic [MAX_NEEDLE-1:0]           mask,
	input  logic [POS_WIDTH-1:0]            limit,
	bss_out_if.source                       result
);
	import bss_pkg::*;

	`include "bounded_substring_search_assert.svh"

	logic [MAX_NEEDLE-1:0][7:0] win_q;
	logic [POS_WIDTH-1:0]       cnt_q;
	logic                       done_q;
	logic                       hit_q;
	logic [POS_WIDTH-1:0]       pos_q;

	logic                       out_valid_q;
	logic                       fin_q;
	logic                       found_q;
	logic [POS_WIDTH-1:0]       match_pos_q;

	logic                       fire;
	logic [MAX_NEEDLE-1:0][7:0] win_base;
	logic [MAX_NEEDLE-1:0][7:0] win_new;
	logic [MAX_NEEDLE-1:0]      slot_ok;
	logic                       match;
	logic [POS_WIDTH-1:0]       cnt_base;
	logic [POS_WIDTH-1:0]       cnt_inc;
	logic [POS_WIDTH-1:0]       len_ext;
	logic                       empty_start;

	logic [MAX_NEEDLE-1:0][7:0] win_d;
	logic [POS_WIDTH-1:0]       cnt_d;
	logic                       done_d;
	logic                       hit_d;
	logic [POS_WIDTH-1:0]       pos_d;

	// Take the queue head whenever the output register is free or being drained.
	assign fire = head.valid && (!out_valid_q || result.ready);
	assign pop  = fire;

	// A first byte starts from a cleared window and a zero count.
	always_comb begin
		for (int k = 0; k < MAX_NEEDLE; k++) begin
			win_base[k] = head.item.first ? 8'h00 : win_q[k];
		end
		win_new[0] = head.item.hay_byte;
		for (int k = 1; k < MAX_NEEDLE; k++) begin
			win_new[k] = win_base[k-1];
		end
	end

	assign cnt_base = head.item.first ? '0 : cnt_q;
	assign cnt_inc  = cnt_base + POS_WIDTH'(1);
	assign len_ext  = POS_WIDTH'(eff_len);

	// Parallel compare of the shifted window against the reversed needle.
	always_comb begin
		for (int k = 0; k < MAX_NEEDLE; k++) begin
			slot_ok[k] = !mask[k] || (win_new[k] == pattern[k]);
		end
	end
	assign match = &slot_ok;

	// Next search state for the byte at the queue head.
	always_comb begin
		win_d  = win_base;
		cnt_d  = cnt_base;
		done_d = head.item.first ? 1'b0 : done_q;
		hit_d  = head.item.first ? 1'b0 : hit_q;
		pos_d  = head.item.first ? '0 : pos_q;
		if (head.item.first) begin
			if (eff_len == '0) begin
				done_d = 1'b1;
				hit_d  = 1'b1;
			end else if (len_ext > limit) begin
				done_d = 1'b1;
			end
		end
		if (!done_d) begin
			if (head.item.term) begin
				done_d = 1'b1;
				hit_d  = 1'b0;
				pos_d  = '0;
			end else begin
				win_d = win_new;
				cnt_d = cnt_inc;
				if ((cnt_inc >= len_ext) && match) begin
					done_d = 1'b1;
					hit_d  = 1'b1;
					pos_d  = cnt_inc - len_ext;
				end else if (cnt_inc >= limit) begin
					done_d = 1'b1;
				end
			end
		end
	end

	// Search state advances once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			cnt_q  <= '0;
			done_q <= 1'b1;
			hit_q  <= 1'b0;
			pos_q  <= '0;
		end else if (fire) begin
			win_q  <= win_d;
			cnt_q  <= cnt_d;
			done_q <= done_d;
			hit_q  <= hit_d;
			pos_q  <= pos_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; only meaningful while the valid flag is set.
	always_ff @(posedge clk) begin
		if (fire) begin
			fin_q       <= done_d;
			found_q     <= done_d && hit_d;
			match_pos_q <= done_d ? pos_d : '0;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.finished  = fin_q;
	assign result.found     = found_q;
	assign result.match_pos = match_pos_q;

	// A search that opens with an empty needle.
	assign empty_start = fire && head.item.first && (eff_len == '0);

	`BSS_ASSERT_ALWAYS(a_found_is_finished, out_valid_q |-> (!found_q || fin_q))
	`BSS_ASSERT(a_pos_needs_found, (out_valid_q && (match_pos_q != '0)) |-> found_q)
	`BSS_ASSERT(a_empty_needle, empty_start |=> (found_q && (match_pos_q == '0)))

endmodule

// ----- rtl/bounded_substring_search.sv -----
// Bounded substring search top level: configuration registers, front queue, back.
// Depends on bss_pkg, bss_in_if, bss_out_if, bss_cfg, bss_front and bss_back.
//
// Usage:
//   The needle, its length and the search limit are written through the plain
//   write port (cfg_wen, cfg_index, cfg_data) while no search is in flight.
//   Haystack bytes arrive on the hay channel, one per transaction; the byte
//   flagged first opens a new search at index 0, and a zero byte ends it.
//   Every hay transaction yields exactly one transaction on the result channel:
//   finished, found and match_pos describe the search after that byte.
//   Once a search has ended, further bytes repeat its result until the next
//   first flag.
//   Each accepted hay byte passes through the queue and then the output
//   register before result valid rises; the window compare is combinational.
//   Throughput is one byte per cycle while the result receiver keeps up.
//   A four-entry queue separates the front from the back. When the result
//   receiver stalls, the output register holds its transaction, the queue
//   fills and hay.ready drops once it is full.
//   Reset clears the configuration, empties the queue, drops result valid and
//   leaves no search active.
module bounded_substring_search #(
	parameter int MAX_NEEDLE = bss_pkg::DEF_MAX_NEEDLE,
	parameter int POS_WIDTH  = bss_pkg::DEF_POS_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [bss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bss_pkg::CFG_DATA_W-1:0] cfg_data,
	bss_in_if.sink                         hay,
	bss_out_if.source                      result
);
	import bss_pkg::*;

	localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

	bss_head_t                  head;
	logic                       pop;
	logic [LEN_W-1:0]           eff_len;
	logic [MAX_NEEDLE-1:0][7:0] pattern;
	logic [MAX_NEEDLE-1:0]      mask;
	logic [POS_WIDTH-1:0]       limit;

	// Configuration registers and derived compare values.
	bss_cfg #(
		.MAX_NEEDLE(MAX_NEEDLE),
		.POS_WIDTH (POS_WIDTH)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.eff_len  (eff_len),
		.pattern  (pattern),
		.mask     (mask),
		.limit    (limit)
	);

	// Accept and classify haystack bytes into the queue.
	bss_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.hay   (hay),
		.head  (head),
		.pop   (pop)
	);

	// Run the search and present results.
	bss_back #(
		.MAX_NEEDLE(MAX_NEEDLE),
		.POS_WIDTH (POS_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.eff_len(eff_len),
		.pattern(pattern),
		.mask   (mask),
		.limit  (limit),
		.result (result)
	);

endmodule

// ----- tb/bounded_substring_search_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bounded_substring_search: directed and random haystacks
// go through the hay channel and every result transaction is checked against a predictor.
// Depends on bss_pkg, bss_in_if, bss_out_if and the bounded_substring_search RTL.
module bounded_substring_search_tb;
	import bss_pkg::*;

	typedef struct packed {
		logic [7:0] hay_byte;
		logic       first;
	} hay_item_t;

	typedef struct packed {
		logic        finished;
		logic        found;
		logic [15:0] match_pos;
	} search_status_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bss_in_if                     hay_ch();
	bss_out_if #(.POS_WIDTH(16))  result_ch();

	bounded_substring_search #(
		.MAX_NEEDLE(16),
		.POS_WIDTH(16)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.hay(hay_ch),
		.result(result_ch)
	);

	// Predictor copy of the configuration registers.
	logic [4:0]  needle_len_q;
	logic [63:0] needle_lo_q;
	logic [63:0] needle_hi_q;
	logic [15:0] limit_q;

	// Predictor copy of the search state.
	logic [7:0]  win_bytes [16];
	int unsigned seen_count;
	logic        search_done;
	logic        search_hit;
	logic [15:0] hit_index;

	hay_item_t      hay_queue [$];
	search_status_t expected_status [$];
	int             mismatches;
	int             queued;
	int unsigned    send_idle_pct;
	int unsigned    recv_idle_pct;

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Needle byte j as held in the two needle registers.
	function automatic logic [7:0] needle_at(int unsigned j);
		if (j < 8) begin
			return needle_lo_q[8*j +: 8];
		end else if (j < 16) begin
			return needle_hi_q[8*(j-8) +: 8];
		end
		return 8'h00;
	endfunction

	// Usable needle length: saturated at 16 and cut at the first zero byte.
	function automatic int unsigned needle_span();
		int unsigned n;
		n = (needle_len_q > 16) ? 16 : needle_len_q;
		for (int unsigned j = 0; j < n; j++) begin
			if (needle_at(j) == 8'h00) begin
				return j;
			end
		end
		return n;
	endfunction

	// Advances the search by one haystack byte and returns the status after it.
	function automatic search_status_t step_search(logic [7:0] hb, logic fst);
		int unsigned    span;
		logic           hit_now;
		search_status_t st;
		span = needle_span();
		if (fst) begin
			for (int k = 0; k < 16; k++) begin
				win_bytes[k] = 8'h00;
			end
			seen_count  = 0;
			search_done = 1'b0;
			search_hit  = 1'b0;
			hit_index   = '0;
			if (span == 0) begin
				search_done = 1'b1;
				search_hit  = 1'b1;
			end else if (span > limit_q) begin
				search_done = 1'b1;
			end
		end
		if (!search_done) begin
			if (hb == 8'h00) begin
				search_done = 1'b1;
				search_hit  = 1'b0;
				hit_index   = '0;
			end else begin
				for (int k = 15; k > 0; k--) begin
					win_bytes[k] = win_bytes[k-1];
				end
				win_bytes[0] = hb;
				if (seen_count < 32'h1FFF_FFFF) begin
					seen_count++;
				end
				// The newest span bytes, oldest first, must equal the needle.
				hit_now = (seen_count >= span);
				for (int unsigned k = 0; k < span; k++) begin
					if (needle_at(k) != win_bytes[span-1-k]) begin
						hit_now = 1'b0;
					end
				end
				if (hit_now) begin
					search_done = 1'b1;
					search_hit  = 1'b1;
					hit_index   = 16'(seen_count - span);
				end else if (seen_count >= limit_q) begin
					search_done = 1'b1;
					search_hit  = 1'b0;
					hit_index   = '0;
				end
			end
		end
		st.finished  = search_done;
		st.found     = search_done && search_hit;
		st.match_pos = search_done ? hit_index : 16'h0000;
		return st;
	endfunction

	task automatic report_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Driver: presents queued hay transactions and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hay_ch.valid    <= 1'b0;
			hay_ch.hay_byte <= 8'h00;
			hay_ch.first    <= 1'b0;
		end else begin
			if (!hay_ch.valid || hay_ch.ready) begin
				if (hay_ch.valid) begin
					expected_status.push_back(step_search(hay_ch.hay_byte, hay_ch.first));
				end
				if (hay_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					hay_ch.valid    <= 1'b1;
					hay_ch.hay_byte <= hay_queue[0].hay_byte;
					hay_ch.first    <= hay_queue[0].first;
					void'(hay_queue.pop_front());
				end else begin
					hay_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result transaction against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		search_status_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_status.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none actual %0d/%0d/%0d", $time,
						result_ch.finished, result_ch.found, result_ch.match_pos);
				end else begin
					want = expected_status.pop_front();
					report_field("finished", want.finished, result_ch.finished);
					report_field("found", want.found, result_ch.found);
					report_field("match_pos", want.match_pos, result_ch.match_pos);
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_item(logic [7:0] hb, logic fst);
		hay_item_t it;
		it.hay_byte = hb;
		it.first    = fst;
		hay_queue.push_back(it);
		queued++;
	endtask

	// Register write; the predictor takes the new value as soon as the write is driven, before the DUT captures it.
	task automatic write_reg(bss_reg_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_NEEDLE_LEN:   needle_len_q = val[4:0];
			REG_NEEDLE_LO:    needle_lo_q  = val;
			REG_NEEDLE_HI:    needle_hi_q  = val;
			REG_SEARCH_LIMIT: limit_q      = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Waits until every queued transaction has been accepted and checked.
	task automatic drain();
		@(negedge clk);
		while (hay_queue.size() != 0 || hay_ch.valid || expected_status.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Haystack byte biased toward needle bytes so that partial matches are common.
	function automatic logic [7:0] pick_byte(int unsigned span);
		int unsigned r;
		r = $urandom_range(9);
		if (r < 6 && span > 0) begin
			return needle_at($urandom_range(0, span - 1));
		end else if (r < 8) begin
			return 8'h61 + 8'($urandom_range(0, 3));
		end
		return 8'($urandom_range(1, 255));
	endfunction

	// One search: first byte flagged, random body, often a planted needle and a terminator.
	task automatic queue_search();
		int unsigned span;
		int unsigned len;
		int unsigned at;
		logic [7:0]  body [$];
		span = needle_span();
		len  = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 20);
		for (int unsigned i = 0; i < len; i++) begin
			body.push_back(pick_byte(span));
		end
		if (span > 0 && len >= span && $urandom_range(9) < 6) begin
			at = $urandom_range(0, len - span);
			for (int unsigned j = 0; j < span; j++) begin
				body[at + j] = needle_at(j);
			end
		end
		if ($urandom_range(9) < 7) begin
			body.push_back(8'h00);
		end
		if (body.size() == 0) begin
			body.push_back(pick_byte(span));
		end
		foreach (body[i]) begin
			push_item(body[i], i == 0);
		end
		repeat ($urandom_range(0, 2)) push_item(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// New random register setting for one phase, with extremes mixed in.
	task automatic random_setup(int phase);
		int unsigned r;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [7:0]  b;
		logic [4:0]  len;
		logic [15:0] lim;
		r = $urandom_range(19);
		if (r == 0) begin
			len = 5'd0;
		end else if (r == 1) begin
			len = 5'($urandom_range(17, 31));
		end else if (r < 6) begin
			len = 5'($urandom_range(9, 16));
		end else begin
			len = 5'($urandom_range(1, 8));
		end
		for (int k = 0; k < 8; k++) begin
			b = ($urandom_range(4) == 0) ? 8'($urandom_range(1, 255))
				: 8'h61 + 8'($urandom_range(0, 3));
			if ($urandom_range(29) == 0) begin
				b = 8'h00;
			end
			lo[8*k +: 8] = b;
			b = ($urandom_range(4) == 0) ? 8'($urandom_range(1, 255))
				: 8'h61 + 8'($urandom_range(0, 3));
			if ($urandom_range(29) == 0) begin
				b = 8'h00;
			end
			hi[8*k +: 8] = b;
		end
		if (phase % 7 == 3) begin
			lo  = '1;
			hi  = '1;
			len = 5'd16;
		end else if (phase % 7 == 5) begin
			lo = '0;
			hi = '0;
		end else if (phase % 7 == 1) begin
			len = 5'd31;
		end
		r = $urandom_range(9);
		if (r == 0) begin
			lim = 16'hFFFF;
		end else if (r == 1) begin
			lim = 16'($urandom_range(0, 65535));
		end else if (r == 2) begin
			lim = 16'($urandom_range(0, 3));
		end else begin
			lim = 16'($urandom_range(1, 24));
		end
		write_reg(REG_NEEDLE_LEN, 64'(len));
		write_reg(REG_NEEDLE_LO, lo);
		write_reg(REG_NEEDLE_HI, hi);
		write_reg(REG_SEARCH_LIMIT, 64'(lim));
	endtask

	// Stimulus and end of run.
	initial begin
		int phase;
		int target;
		arst_n          = 1'b0;
		cfg_wen         = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		needle_len_q    = '0;
		needle_lo_q     = '0;
		needle_hi_q     = '0;
		limit_q         = '0;
		for (int k = 0; k < 16; k++) begin
			win_bytes[k] = 8'h00;
		end
		seen_count    = 0;
		search_done   = 1'b1;
		search_hit    = 1'b0;
		hit_index     = '0;
		mismatches    = 0;
		queued        = 0;
		send_idle_pct = 7;
		recv_idle_pct = 84;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// An idle byte before any search, then the empty needle of the reset setting.
		push_item(8'h41, 1'b0);
		push_item(8'h41, 1'b1);
		drain();

		// Needle "ab": empty haystack, a hit at index 1, then an ignored byte.
		write_reg(REG_NEEDLE_LEN, 64'd2);
		write_reg(REG_NEEDLE_LO, 64'h6261);
		write_reg(REG_NEEDLE_HI, '1);
		write_reg(REG_SEARCH_LIMIT, 64'hFFFF);
		push_item(8'h00, 1'b1);
		push_item(8'h78, 1'b1);
		push_item(8'h61, 1'b0);
		push_item(8'h62, 1'b0);
		push_item(8'hFF, 1'b0);
		drain();

		// Needle longer than the limit ends the search on the first byte.
		write_reg(REG_SEARCH_LIMIT, 64'd1);
		push_item(8'h61, 1'b1);
		drain();

		// The limit runs out one byte before the match would complete.
		write_reg(REG_SEARCH_LIMIT, 64'd3);
		push_item(8'h78, 1'b1);
		push_item(8'h78, 1'b0);
		push_item(8'h61, 1'b0);
		push_item(8'h62, 1'b0);
		drain();

		// Saturated length cut at the first zero needle byte: the needle is "abc".
		write_reg(REG_NEEDLE_LEN, 64'd31);
		write_reg(REG_NEEDLE_LO, 64'h0063_6261);
		write_reg(REG_SEARCH_LIMIT, 64'hFFFF);
		push_item(8'h61, 1'b1);
		push_item(8'h62, 1'b0);
		push_item(8'h63, 1'b0);
		drain();

		// Needle emptied in the middle of a search matches at the current count.
		write_reg(REG_NEEDLE_LEN, 64'd2);
		write_reg(REG_NEEDLE_LO, 64'h6261);
		push_item(8'h78, 1'b1);
		push_item(8'h79, 1'b0);
		drain();
		write_reg(REG_NEEDLE_LEN, 64'd0);
		push_item(8'h7A, 1'b0);
		drain();

		// Limit lowered in the middle of a search ends it on the next byte.
		write_reg(REG_NEEDLE_LEN, 64'd2);
		push_item(8'h78, 1'b1);
		push_item(8'h79, 1'b0);
		drain();
		write_reg(REG_SEARCH_LIMIT, 64'd1);
		push_item(8'h7A, 1'b0);
		drain();

		// Zero limit with a non-empty needle.
		write_reg(REG_SEARCH_LIMIT, 64'd0);
		push_item(8'h61, 1'b1);
		drain();

		// Random phases; the idling pattern changes after the fifth and the tenth phase.
		phase = 0;
		while (queued < 950) begin
			if (phase < 5) begin
				send_idle_pct = 7;
				recv_idle_pct = 84;
			end else if (phase < 10) begin
				send_idle_pct = 84;
				recv_idle_pct = 7;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_setup(phase);
			target = queued + 60;
			while (queued < target) begin
				if ($urandom_range(99) < 85) begin
					queue_search();
				end else begin
					repeat ($urandom_range(1, 4)) begin
						push_item(8'($urandom_range(0, 255)), $urandom_range(9) == 0);
					end
				end
			end
			drain();
			phase++;
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_status.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
